FILE: src/ise_pkg.sv
// ----------------------------------------------------------------------------
// ise_pkg
// shared types for the insertion sort engine: beat payloads, cell links,
// cell control and the sequencer state
// ----------------------------------------------------------------------------
package ise_pkg;

  localparam int unsigned VALUE_W = 14;

  typedef logic [VALUE_W-1:0] value_t;

  // input beat
  typedef struct packed {
    value_t item_value;
    logic   last_item;
  } ise_in_t;

  // result beat
  typedef struct packed {
    value_t sorted_value;
    logic   end_of_run;
    logic   overflowed;
  } ise_out_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic   occ;
    logic   gt;
    value_t value;
  } ise_link_t;

  // broadcast control to every cell
  typedef struct packed {
    logic   ins;
    logic   drain;
    value_t value;
  } ise_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } ise_state_t;

endpackage

FILE: src/ise_cell.sv
// ----------------------------------------------------------------------------
// ise_cell
// one slot of the sorted chain: compare-and-shift right on insert,
// shift left on drain
// ----------------------------------------------------------------------------
module ise_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ise_pkg::ise_ctrl_t ctrl,
  input  ise_pkg::ise_link_t left_in,
  input  ise_pkg::ise_link_t right_in,
  output ise_pkg::ise_link_t link_out
);
  import ise_pkg::*;

  logic   occ_r, occ_nxt;
  value_t val_r, val_nxt;
  logic   gt;

  // strictly greater values move up, so equal values keep arrival order
  assign gt = occ_r && (val_r > ctrl.value);

  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    if (ctrl.drain) begin
      occ_nxt = right_in.occ;
      val_nxt = right_in.value;
    end else if (ctrl.ins) begin
      if (left_in.gt) begin
        occ_nxt = 1'b1;
        val_nxt = left_in.value;
      end else if ((gt || !occ_r) && left_in.occ) begin
        // insertion point
        occ_nxt = 1'b1;
        val_nxt = ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link_out.occ   = occ_r;
  assign link_out.gt    = gt;
  assign link_out.value = val_r;

endmodule

FILE: src/insertion_sort_engine.sv
// ----------------------------------------------------------------------------
// insertion_sort_engine
// stable ascending sort of one value set in a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
// While loading, busy stays low and a value may be given
// in every cycle, each one compared against all cells at once and slotted in
// by a one-step right shift of the greater entries. Equal values keep arrival
// order. A value that finds the chain full (MAX_ITEMS held) is dropped and the
// overflow flag set. The beat marked last_item is inserted like any other, and
// from the next cycle busy is high while the chain shifts left one cell per
// cycle, putting out one result beat per cycle on out_valid, N beats for N
// held values, end_of_run on the final one, overflowed on all of them when a
// value was dropped. The receiver cannot stall: each result is on out_data for
// exactly one cycle. After the final beat busy drops and the chain is empty.
// ----------------------------------------------------------------------------
module insertion_sort_engine #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ise_pkg::ise_in_t in_data,
  output logic             busy,
  output logic             out_valid,
  output ise_pkg::ise_out_t out_data
);
  import ise_pkg::*;

  ise_state_t state_r, state_nxt;
  logic       ovf_r, ovf_nxt;
  logic       accept;
  logic       full;
  logic       last_out;
  ise_ctrl_t  ctrl;

  // links between cells: index 0 is a virtual always-occupied head,
  // index MAX_ITEMS+1 a virtual empty tail
  ise_link_t  link [MAX_ITEMS+2];

  assign accept = start && !busy;
  // chain full when the top cell is occupied
  assign full   = link[MAX_ITEMS].occ;
  // no value behind the head cell, so this beat closes the run
  assign last_out = !link[2].occ;

  // broadcast control
  assign ctrl.ins   = accept && !full;
  assign ctrl.drain = (state_r == ST_DRAIN);
  assign ctrl.value = in_data.item_value;

  assign link[0].occ         = 1'b1;
  assign link[0].gt          = 1'b0;
  assign link[0].value       = '0;
  assign link[MAX_ITEMS+1].occ   = 1'b0;
  assign link[MAX_ITEMS+1].gt    = 1'b0;
  assign link[MAX_ITEMS+1].value = '0;

  // the cell chain
  for (genvar i = 1; i <= MAX_ITEMS; i++) begin : g_cell
    ise_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .left_in  (link[i-1]),
      .right_in (link[i+1]),
      .link_out (link[i])
    );
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_data.last_item) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (last_out) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // overflow flag: set on a dropped value, cleared when a run ends
  always_comb begin
    ovf_nxt = ovf_r;
    if (accept && full) begin
      ovf_nxt = 1'b1;
    end else if (ctrl.drain && last_out) begin
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
      ST_DRAIN: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // result beat straight from the head cell
  assign out_data.sorted_value = link[1].value;
  assign out_data.end_of_run   = last_out;
  assign out_data.overflowed   = ovf_r;

`ifndef SYNTHESIS
  // a result beat always comes from an occupied head cell
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> link[1].occ)
    else $error("result beat from empty head cell");

  // the final beat of a run frees the block
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_run) |=> (!busy && !link[1].occ))
    else $error("chain not empty after final beat");

  // beats of a run come back to back
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.end_of_run) |=> out_valid)
    else $error("gap inside a run");

  // overflow only set after the chain was full
  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(full))
    else $error("overflow without a full chain");
`endif

endmodule
